>>> rtl/kwsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types and constants for the keyword substitution cipher.
// ----------------------------------------------------------------------------
package kwsc_pkg;

  localparam int ALPHA_LEN = 26;
  localparam int IDX_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [IDX_W-1:0] ALPHA_COUNT = IDX_W'(ALPHA_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ALPHA_LEN - 1);

  localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;

  // opcodes on the input channel
  localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
  localparam logic [OP_W-1:0] OP_FIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY_KEY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_FIN,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              is_letter;
    logic              is_upper;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] raw;
  } cmd_t;

  typedef struct packed {
    logic             table_ready;
    logic [IDX_W-1:0] fill;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FIN,
    BK_LOOK
  } bk_state_t;

endpackage
`default_nettype wire

>>> rtl/kwsc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_in_if
// Input channel: opcode and byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kwsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink (input valid, input opcode, input in_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/kwsc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_out_if
// Result channel: output byte and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kwsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink (input valid, input out_byte, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/kwsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/kwsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_front
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module kwsc_front (
  kwsc_in_if.sink         req,
  input  logic            q_full,
  output logic            q_push,
  output kwsc_pkg::cmd_t  q_cmd
);
  import kwsc_pkg::*;

  logic is_upper;
  logic is_lower;
  logic known_op;

  assign req.ready = !q_full;

  assign is_upper = (req.in_byte >= UPPER_A) && (req.in_byte <= UPPER_Z);
  assign is_lower = (req.in_byte >= LOWER_A) && (req.in_byte <= LOWER_Z);

  always_comb begin
    q_cmd.is_letter = is_upper || is_lower;
    q_cmd.is_upper  = is_upper;
    // 'A' and 'a' both have 5'b00001 in their low bits
    q_cmd.idx       = req.in_byte[IDX_W-1:0] - IDX_W'(1);
    q_cmd.raw       = req.in_byte;
    q_cmd.kind      = CMD_KEY;
    known_op        = 1'b1;
    unique case (req.opcode)
      OP_KEY:  q_cmd.kind = CMD_KEY;
      OP_FIN:  q_cmd.kind = CMD_FIN;
      OP_DATA: q_cmd.kind = CMD_DATA;
      default: known_op = 1'b0;
    endcase
  end

  // unknown opcodes are taken and dropped
  assign q_push = req.valid && req.ready && known_op;

endmodule
`default_nettype wire

>>> rtl/kwsc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module kwsc_fifo #(
  parameter int DEPTH = kwsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kwsc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output kwsc_pkg::cmd_t head
);
  import kwsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/kwsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_back
// Executes queued commands: table build, finalize walk and data lookup.
// ----------------------------------------------------------------------------
module kwsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               dec_sel,
  input  logic               q_valid,
  input  kwsc_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  kwsc_out_if.source         rsp,
  output kwsc_pkg::bk_stat_t stat
);
  import kwsc_pkg::*;

  bk_state_t               state, state_next;
  logic [ALPHA_LEN-1:0]    mask, mask_next;
  logic [IDX_W-1:0]        fill, fill_next;
  logic                    tbl_ready, tbl_ready_next;
  logic [IDX_W-1:0]        k, k_next;
  logic                    look_upper, look_upper_next;

  logic                    out_valid;
  logic                    out_load;
  logic                    out_free;
  logic [BYTE_W-1:0]       out_byte, out_byte_next;
  logic [STATUS_W-1:0]     out_status, out_status_next;

  logic                    add_req;
  logic                    add_ok;
  logic [IDX_W-1:0]        add_letter;
  logic [ALPHA_LEN-1:0]    base_mask;
  logic [IDX_W-1:0]        base_fill;

  logic [IDX_W-1:0]        cip_rd;
  logic [IDX_W-1:0]        inv_rd;
  logic [IDX_W-1:0]        look_rd;

  assign out_free = !out_valid || rsp.ready;
  assign look_rd  = dec_sel ? inv_rd : cip_rd;

  // plain index -> cipher index
  kwsc_ram #(.WIDTH(IDX_W), .DEPTH(ALPHA_LEN)) u_cipher (
    .clk   (clk),
    .we    (add_ok),
    .waddr (base_fill),
    .wdata (add_letter),
    .raddr (q_cmd.idx),
    .rdata (cip_rd)
  );

  // cipher index -> plain index
  kwsc_ram #(.WIDTH(IDX_W), .DEPTH(ALPHA_LEN)) u_inverse (
    .clk   (clk),
    .we    (add_ok),
    .waddr (add_letter),
    .wdata (base_fill),
    .raddr (q_cmd.idx),
    .rdata (inv_rd)
  );

  always_comb begin
    state_next      = state;
    k_next          = k;
    look_upper_next = look_upper;
    tbl_ready_next  = tbl_ready;
    q_pop           = 1'b0;
    out_load        = 1'b0;
    out_byte_next   = out_byte;
    out_status_next = out_status;
    add_req         = 1'b0;
    add_letter      = q_cmd.idx;
    base_mask       = mask;
    base_fill       = fill;

    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_KEY: begin
              // first key byte after a finished table starts a new keyword
              if (tbl_ready) begin
                base_mask      = '0;
                base_fill      = '0;
                tbl_ready_next = 1'b0;
              end
              add_req = q_cmd.is_letter;
            end
            CMD_FIN: begin
              if (fill == '0) begin
                out_load        = 1'b1;
                out_byte_next   = '0;
                out_status_next = ST_EMPTY_KEY;
              end else if (tbl_ready) begin
                out_load        = 1'b1;
                out_byte_next   = '0;
                out_status_next = ST_OK;
              end else begin
                state_next = BK_FIN;
                k_next     = LAST_IDX;
              end
            end
            CMD_DATA: begin
              if (!tbl_ready) begin
                out_load        = 1'b1;
                out_byte_next   = q_cmd.raw;
                out_status_next = ST_NOT_READY;
              end else if (!q_cmd.is_letter) begin
                out_load        = 1'b1;
                out_byte_next   = q_cmd.raw;
                out_status_next = ST_OK;
              end else begin
                state_next      = BK_LOOK;
                look_upper_next = q_cmd.is_upper;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_FIN: begin
        // append unused letters from z down to a
        add_req    = 1'b1;
        add_letter = k;
        if (k == '0) begin
          out_load        = 1'b1;
          out_byte_next   = '0;
          out_status_next = ST_OK;
          tbl_ready_next  = 1'b1;
          state_next      = BK_IDLE;
        end else begin
          k_next = k - IDX_W'(1);
        end
      end
      BK_LOOK: begin
        out_load        = 1'b1;
        out_byte_next   = {{(BYTE_W-IDX_W){1'b0}}, look_rd} + (look_upper ? UPPER_A : LOWER_A);
        out_status_next = ST_OK;
        state_next      = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase

    add_ok    = add_req && !base_mask[add_letter] && (base_fill < ALPHA_COUNT);
    mask_next = base_mask | (add_ok ? (ALPHA_LEN'(1) << add_letter) : '0);
    fill_next = base_fill + IDX_W'(add_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      mask      <= '0;
      fill      <= '0;
      tbl_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mask      <= mask_next;
      fill      <= fill_next;
      tbl_ready <= tbl_ready_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    look_upper <= look_upper_next;
    out_byte   <= out_byte_next;
    out_status <= out_status_next;
  end

  assign rsp.valid    = out_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.status   = out_status;

  assign stat.table_ready = tbl_ready;
  assign stat.fill        = fill;

endmodule
`default_nettype wire

>>> rtl/keyword_substitution_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword monoalphabetic substitution cipher with a byte-wide stream port.
// ----------------------------------------------------------------------------
// Each req transaction carries an opcode and a byte. Key bytes build the
// cipher alphabet, finalize fills in the unused letters from Z down to A,
// data bytes are substituted (or inverted when dec_sel is set) and
// keep their case. Accepted transactions wait in a short queue, so the input
// keeps flowing while a result waits on rsp, until the queue fills. Queued
// commands are registered before reaching the back part; key bytes and data
// bytes without a lookup are handled in BK_IDLE, a table lookup also passes
// BK_LOOK (registered table RAM read), and a finalize that builds the table
// walks BK_FIN one letter per cycle over the 26 letters. The user must write
// dec_sel through cfg_we/cfg_wdata only while the block is idle; unenforced.
module keyword_substitution_cipher #(
  parameter int QUEUE_DEPTH = kwsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  kwsc_in_if.sink     req,
  kwsc_out_if.source  rsp
);
  import kwsc_pkg::*;

  logic     dec_sel;
  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  cmd_t     push_cmd;
  cmd_t     head_cmd;
  bk_stat_t bk_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_sel <= 1'b0;
    end else if (cfg_we) begin
      dec_sel <= cfg_wdata;
    end
  end

  kwsc_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  kwsc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  kwsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .dec_sel (dec_sel),
    .q_valid (q_valid),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp),
    .stat    (bk_stat)
  );

  // a complete table always holds every letter
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    bk_stat.table_ready |-> (bk_stat.fill == ALPHA_COUNT))
    else $error("table ready with missing letters");

  // finishing the table comes with the finalize transaction result
  a_ready_result: assert property (@(posedge clk) disable iff (rst)
    $rose(bk_stat.table_ready) |-> (rsp.valid && (rsp.status == ST_OK)))
    else $error("table completed without finalize result");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    bk_stat.fill <= ALPHA_COUNT)
    else $error("table fill count out of range");

endmodule
`default_nettype wire

>>> tb/tb_keyword_substitution_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher
// Self-checking bench for the keyword substitution cipher. A directed table
// covers the corner cases: data before a table exists, empty keywords,
// repeated finalize, an unused opcode, non-letter bytes and letter extremes.
// Random keyword/finalize/data sequences follow in both cipher directions.
// Every accepted request goes through an in-bench model of the cipher
// alphabet. Each response is compared against the oldest expected one. The
// sender works in bursts, the receiver stalls on a changing pattern, and
// one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
  import kwsc_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 100;
  localparam int LIMIT_TIME   = 3_000_000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   b;
    logic                typed;
    logic                has_res;
    logic [BYTE_W-1:0]   exp_byte;
    logic [STATUS_W-1:0] exp_status;
  } plan_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
  } cipher_result_t;

  localparam int PLAN_LEN = 25;
  plan_row_t corner_plan [PLAN_LEN] = '{
    '{OP_DATA, 8'h61, 1'b1, 1'b1, 8'h61, ST_NOT_READY},
    '{OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF, ST_NOT_READY},
    '{OP_FIN,  8'h00, 1'b1, 1'b1, 8'h00, ST_EMPTY_KEY},
    '{OP_NONE, 8'h41, 1'b1, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h40, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h7B, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_FIN,  8'h00, 1'b1, 1'b1, 8'h00, ST_EMPTY_KEY},
    '{OP_KEY,  8'h7A, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h45, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h62, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h5A, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_KEY,  8'h60, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_FIN,  8'h00, 1'b1, 1'b1, 8'h00, ST_OK},
    '{OP_FIN,  8'hFF, 1'b1, 1'b1, 8'h00, ST_OK},
    '{OP_DATA, 8'h41, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_DATA, 8'h5A, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_DATA, 8'h61, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_DATA, 8'h7A, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_DATA, 8'h5B, 1'b1, 1'b1, 8'h5B, ST_OK},
    '{OP_DATA, 8'h00, 1'b1, 1'b1, 8'h00, ST_OK},
    '{OP_DATA, 8'h80, 1'b1, 1'b1, 8'h80, ST_OK},
    '{OP_KEY,  8'h51, 1'b0, 1'b0, 8'h00, ST_OK},
    '{OP_DATA, 8'h71, 1'b1, 1'b1, 8'h71, ST_NOT_READY}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  kwsc_in_if  req_if ();
  kwsc_out_if rsp_if ();

  keyword_substitution_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #5 clk = ~clk;

  // cipher alphabet model
  logic [IDX_W-1:0] subst_fwd [ALPHA_LEN];
  logic [IDX_W-1:0] subst_inv [ALPHA_LEN];
  logic [ALPHA_LEN-1:0] letters_taken;
  logic [IDX_W-1:0] key_len;
  logic alphabet_done;
  logic decrypt_on;

  plan_row_t      issued_rows [$];
  cipher_result_t pending_results [$];
  int errors = 0;
  int sent_count = 0;
  int burst_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  function automatic bit is_upper(logic [BYTE_W-1:0] b);
    return b >= UPPER_A && b <= UPPER_Z;
  endfunction

  function automatic bit is_lower(logic [BYTE_W-1:0] b);
    return b >= LOWER_A && b <= LOWER_Z;
  endfunction

  function automatic void alphabet_clear();
    for (int k = 0; k < ALPHA_LEN; k++) begin
      subst_fwd[k] = '0;
      subst_inv[k] = '0;
    end
    letters_taken = '0;
    key_len = '0;
    alphabet_done = 1'b0;
  endfunction

  function automatic void alphabet_append(logic [IDX_W-1:0] idx);
    if (!letters_taken[idx] && key_len < ALPHA_COUNT) begin
      subst_fwd[key_len] = idx;
      letters_taken[idx] = 1'b1;
      key_len = key_len + IDX_W'(1);
    end
  endfunction

  function automatic bit cipher_predict(input logic [OP_W-1:0] op,
                                        input logic [BYTE_W-1:0] b,
                                        output cipher_result_t r);
    logic [BYTE_W-1:0] base;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] sub;
    r = '0;
    base = is_upper(b) ? UPPER_A : LOWER_A;
    idx = IDX_W'(b - base);
    case (op)
      OP_KEY: begin
        if (alphabet_done) alphabet_clear();
        if (is_upper(b) || is_lower(b)) alphabet_append(idx);
        return 1'b0;
      end
      OP_FIN: begin
        if (key_len == 0) begin
          r.status = ST_EMPTY_KEY;
          return 1'b1;
        end
        if (!alphabet_done) begin
          for (int k = ALPHA_LEN - 1; k >= 0; k--) alphabet_append(IDX_W'(k));
          for (int k = 0; k < ALPHA_LEN; k++) subst_inv[subst_fwd[k]] = IDX_W'(k);
          alphabet_done = 1'b1;
        end
        r.status = ST_OK;
        return 1'b1;
      end
      OP_DATA: begin
        r.out_byte = b;
        if (!alphabet_done) begin
          r.status = ST_NOT_READY;
          return 1'b1;
        end
        if (is_upper(b) || is_lower(b)) begin
          sub = decrypt_on ? subst_inv[idx] : subst_fwd[idx];
          r.out_byte = base + BYTE_W'(sub);
        end
        r.status = ST_OK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch_channels
    cipher_result_t seen;
    cipher_result_t want;
    plan_row_t row;
    bit produces;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen.out_byte = rsp_if.out_byte;
        seen.status = rsp_if.status;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction out_byte %02h status %0d",
                                    seen.out_byte, seen.status));
        end else begin
          want = pending_results.pop_front();
          if (seen.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      seen.out_byte, want.out_byte));
          if (seen.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      seen.status, want.status));
        end
      end
      if (req_if.valid && req_if.ready && issued_rows.size() != 0) begin
        row = issued_rows.pop_front();
        produces = cipher_predict(req_if.opcode, req_if.in_byte, want);
        if (row.typed) begin
          produces = row.has_res;
          want.out_byte = row.exp_byte;
          want.status = row.exp_status;
        end
        if (produces) pending_results.push_back(want);
      end
    end
  end

  // receiver: ready follows a random stall pattern that changes over the run, plus one long hold
  initial begin : rsp_stall
    int cyc;
    logic [7:0] pat;
    cyc = 0;
    pat = 8'hFF;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (cyc % 64 == 0)
        pat = ($urandom_range(0, 3) == 0) ? 8'hFF
              : (8'($urandom) | (8'd1 << $urandom_range(0, 7)));
      rsp_if.ready <= pat[cyc % 8];
      cyc++;
    end
  end

  task automatic send_row(plan_row_t row);
    issued_rows.push_back(row);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.opcode <= row.op;
    req_if.in_byte <= row.b;
    do @(posedge clk); while (!req_if.ready);
    sent_count++;
  endtask

  task automatic send_free(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.b = b;
    send_row(row);
  endtask

  function automatic logic [BYTE_W-1:0] any_letter();
    return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + BYTE_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [BYTE_W-1:0] any_non_letter();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (is_upper(b) || is_lower(b)) b = b ^ 8'h80;
    return b;
  endfunction

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0 || issued_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    decrypt_on = m;
    cfg_we <= 1'b0;
  endtask

  task automatic run_sequences(int n);
    int start;
    int kind;
    int len;
    int j;
    int tmp;
    logic [BYTE_W-1:0] perm [ALPHA_LEN];
    start = sent_count;
    while (sent_count - start < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if ($urandom_range(0, 7) == 0) begin
          // keyword holding every letter
          for (int k = 0; k < ALPHA_LEN; k++) perm[k] = UPPER_A + BYTE_W'(k);
          for (int k = ALPHA_LEN - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = BYTE_W'(tmp);
          end
          for (int k = 0; k < ALPHA_LEN; k++)
            send_free(OP_KEY, $urandom_range(0, 1) ? perm[k] : perm[k] | 8'h20);
        end else begin
          len = $urandom_range(1, 14);
          for (int k = 0; k < len; k++)
            send_free(OP_KEY, ($urandom_range(0, 5) == 0) ? any_non_letter() : any_letter());
        end
        send_free(OP_FIN, BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) send_free(OP_FIN, BYTE_W'($urandom_range(0, 255)));
        len = $urandom_range(3, 20);
        for (int k = 0; k < len; k++)
          send_free(OP_DATA, ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                        : any_letter());
      end else if (kind == 7) begin
        // data while no table exists
        send_free(OP_KEY, any_letter());
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) send_free(OP_DATA, BYTE_W'($urandom_range(0, 255)));
        send_free(OP_FIN, BYTE_W'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        // keyword without letters
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) send_free(OP_KEY, any_non_letter());
        send_free(OP_FIN, BYTE_W'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_free(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    #(LIMIT_TIME);
    $display("tb_keyword_substitution_cipher failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.opcode <= OP_KEY;
    req_if.in_byte <= '0;
    alphabet_clear();
    decrypt_on = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(1'b0);
    for (int i = 0; i < PLAN_LEN; i++) send_row(corner_plan[i]);

    write_mode(1'b1);
    run_sequences(80);
    write_mode(1'b0);
    run_sequences(20);
    hold_go = 1'b1;
    run_sequences(60);
    write_mode(1'b1);
    run_sequences(80);
    write_mode(1'b0);
    run_sequences(80);

    wait_drained();
    if (errors == 0)
      $display("tb_keyword_substitution_cipher passed");
    else
      $display("tb_keyword_substitution_cipher failed");
    $finish;
  end

endmodule
`default_nettype wire
